// ===== hw/rtl/cvs_pkg.sv =====
// Package for the circle follow steering vector unit.
// Holds the request and result types, register indexes and the cell state types.
// It depends on nothing else.
package cvs_pkg;

    localparam logic [1:0] REG_CENTER_X = 2'd0;
    localparam logic [1:0] REG_CENTER_Z = 2'd1;
    localparam logic [1:0] REG_RADIUS   = 2'd2;

    localparam int SQRT_CELLS = 33;
    localparam int DIV_CELLS  = 65;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] steer_x;
        logic signed [31:0] steer_z;
        logic               at_center;
    } res_t;

    typedef struct packed {
        logic [65:0] s;
        logic [34:0] rem;
        logic [32:0] root;
    } sqrt_st_t;

    typedef struct packed {
        logic [63:0]        mag_x;
        logic               neg_x;
        logic [63:0]        mag_z;
        logic               neg_z;
        logic signed [32:0] dx;
        logic signed [32:0] dz;
    } side_a_t;

    typedef struct packed {
        logic [64:0] num;
        logic [32:0] rem;
        logic [40:0] q;
        logic        ovf;
    } div_lane_t;

    typedef struct packed {
        logic               neg_x;
        logic               neg_z;
        logic signed [32:0] dx;
        logic signed [32:0] dz;
        logic               zero;
        logic [32:0]        len;
    } side_b_t;

endpackage

// ===== hw/rtl/circle_follow_steering_vector_unit.sv =====
// Top level of the circle follow steering vector unit.
// Each request passes p0, p1, p2, the square root chain, p3, the divider chain and out_reg.
// A new request is taken every cycle; busy stays low, set by the 33 cell square root
// chain and the 65 cell divider chain that both advance every cycle.
// The receiver cannot stall; each result is shown for one cycle with res_valid.
// Reset clears all valid bits and the registers center_x, center_z and radius to zero.
module circle_follow_steering_vector_unit
    import cvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  req_t        req,
    input  logic        wr_en,
    input  logic [1:0]  wr_index,
    input  logic [31:0] wr_data,
    output logic        res_valid,
    output res_t        res
);

    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_z_reg;
    logic [30:0]        radius_reg;

    logic               p0_valid_reg;
    logic signed [32:0] p0_dx_reg;
    logic signed [32:0] p0_dz_reg;

    logic               p1_valid_reg;
    logic signed [32:0] p1_dx_reg;
    logic signed [32:0] p1_dz_reg;
    logic [65:0]        p1_sqx_reg;
    logic [65:0]        p1_sqz_reg;
    logic [63:0]        p1_m1x_reg;
    logic [63:0]        p1_m1z_reg;
    logic [32:0]        abs_dx;
    logic [32:0]        abs_dz;

    logic               p2_valid_reg;
    sqrt_st_t           p2_st_reg;
    side_a_t            p2_side_reg;
    logic [32:0]        abs1_dx;
    logic [32:0]        abs1_dz;
    logic [63:0]        mag_x_next;
    logic [63:0]        mag_z_next;
    logic               neg_x_next;
    logic               neg_z_next;

    logic               sq_valid [0:SQRT_CELLS];
    sqrt_st_t           sq_st    [0:SQRT_CELLS];
    side_a_t            sq_side  [0:SQRT_CELLS];

    logic               p3_valid_reg;
    div_lane_t          p3_x_reg;
    div_lane_t          p3_z_reg;
    side_b_t            p3_side_reg;
    logic [32:0]        len;

    logic               dv_valid [0:DIV_CELLS];
    div_lane_t          dv_x     [0:DIV_CELLS];
    div_lane_t          dv_z     [0:DIV_CELLS];
    side_b_t            dv_side  [0:DIV_CELLS];

    logic               out_valid_reg;
    res_t               out_reg;
    res_t               out_next;

    function automatic void combine(input logic n1, input logic [63:0] m1, input logic n2,
                                    input logic [63:0] m2, output logic neg,
                                    output logic [63:0] mag);
        if (m1 == 64'd0)
        begin
            neg = n2;
            mag = m2;
        end
        else if (m2 == 64'd0)
        begin
            neg = n1;
            mag = m1;
        end
        else if (n1 == n2)
        begin
            neg = n1;
            mag = m1 + m2;
        end
        else if (m1 >= m2)
        begin
            neg = n1;
            mag = m1 - m2;
        end
        else
        begin
            neg = n2;
            mag = m2 - m1;
        end
    endfunction

    function automatic logic signed [31:0] finish(input logic signed [32:0] d,
                                                  input div_lane_t l, input logic neg);
        logic [40:0]        q;
        logic signed [42:0] sum;
        if (l.ovf || (l.q[40] && (l.q[39:0] != 40'd0)))
        begin
            q = {1'b1, 40'd0};
        end
        else
        begin
            q = l.q;
        end
        if (neg)
        begin
            sum = 43'(d) - $signed({2'b00, q});
        end
        else
        begin
            sum = 43'(d) + $signed({2'b00, q});
        end
        if (sum > 43'sd2147483647)
        begin
            return 32'sh7fffffff;
        end
        else if (sum < -43'sd2147483648)
        begin
            return 32'sh80000000;
        end
        else
        begin
            return sum[31:0];
        end
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= '0;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CENTER_X: center_x_reg <= wr_data;
                REG_CENTER_Z: center_z_reg <= wr_data;
                REG_RADIUS:   radius_reg   <= wr_data[30:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_valid_reg  <= 1'b0;
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p0_valid_reg  <= start;
            p1_valid_reg  <= p0_valid_reg;
            p2_valid_reg  <= p1_valid_reg;
            p3_valid_reg  <= sq_valid[SQRT_CELLS];
            out_valid_reg <= dv_valid[DIV_CELLS];
        end
    end

    assign abs_dx = p0_dx_reg[32] ? 33'(-p0_dx_reg) : p0_dx_reg;
    assign abs_dz = p0_dz_reg[32] ? 33'(-p0_dz_reg) : p0_dz_reg;

    assign abs1_dx = p1_dx_reg[32] ? 33'(-p1_dx_reg) : p1_dx_reg;
    assign abs1_dz = p1_dz_reg[32] ? 33'(-p1_dz_reg) : p1_dz_reg;

    always_comb
    begin
        combine(p1_dx_reg > 0, p1_m1x_reg, p1_dz_reg > 0, {17'd0, abs1_dz, 14'd0},
                neg_x_next, mag_x_next);
        combine(p1_dz_reg > 0, p1_m1z_reg, p1_dx_reg < 0, {17'd0, abs1_dx, 14'd0},
                neg_z_next, mag_z_next);
    end

    always_ff @(posedge clk)
    begin
        p0_dx_reg <= 33'(center_x_reg) - 33'(req.pos_x);
        p0_dz_reg <= 33'(center_z_reg) - 33'(req.pos_z);

        p1_dx_reg  <= p0_dx_reg;
        p1_dz_reg  <= p0_dz_reg;
        p1_sqx_reg <= abs_dx * abs_dx;
        p1_sqz_reg <= abs_dz * abs_dz;
        p1_m1x_reg <= abs_dx * radius_reg;
        p1_m1z_reg <= abs_dz * radius_reg;

        p2_st_reg.s          <= p1_sqx_reg + p1_sqz_reg;
        p2_st_reg.rem        <= '0;
        p2_st_reg.root       <= '0;
        p2_side_reg.mag_x    <= mag_x_next;
        p2_side_reg.neg_x    <= neg_x_next;
        p2_side_reg.mag_z    <= mag_z_next;
        p2_side_reg.neg_z    <= neg_z_next;
        p2_side_reg.dx       <= p1_dx_reg;
        p2_side_reg.dz       <= p1_dz_reg;
    end

    assign sq_valid[0] = p2_valid_reg;
    assign sq_st[0]    = p2_st_reg;
    assign sq_side[0]  = p2_side_reg;

    for (genvar i = 0; i < SQRT_CELLS; i++)
    begin : g_sqrt
        cvs_sqrt_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sq_valid[i]),
            .st_in     (sq_st[i]),
            .side_in   (sq_side[i]),
            .valid_out (sq_valid[i+1]),
            .st_out    (sq_st[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    assign len = sq_st[SQRT_CELLS].root;

    always_ff @(posedge clk)
    begin
        p3_x_reg.num      <= 65'(sq_side[SQRT_CELLS].mag_x) + 65'(len[32:1]);
        p3_x_reg.rem      <= '0;
        p3_x_reg.q        <= '0;
        p3_x_reg.ovf      <= 1'b0;
        p3_z_reg.num      <= 65'(sq_side[SQRT_CELLS].mag_z) + 65'(len[32:1]);
        p3_z_reg.rem      <= '0;
        p3_z_reg.q        <= '0;
        p3_z_reg.ovf      <= 1'b0;
        p3_side_reg.neg_x <= sq_side[SQRT_CELLS].neg_x;
        p3_side_reg.neg_z <= sq_side[SQRT_CELLS].neg_z;
        p3_side_reg.dx    <= sq_side[SQRT_CELLS].dx;
        p3_side_reg.dz    <= sq_side[SQRT_CELLS].dz;
        p3_side_reg.zero  <= (len == 33'd0);
        p3_side_reg.len   <= len;
    end

    assign dv_valid[0] = p3_valid_reg;
    assign dv_x[0]     = p3_x_reg;
    assign dv_z[0]     = p3_z_reg;
    assign dv_side[0]  = p3_side_reg;

    for (genvar j = 0; j < DIV_CELLS; j++)
    begin : g_div
        cvs_div_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (dv_valid[j]),
            .x_in      (dv_x[j]),
            .z_in      (dv_z[j]),
            .side_in   (dv_side[j]),
            .valid_out (dv_valid[j+1]),
            .x_out     (dv_x[j+1]),
            .z_out     (dv_z[j+1]),
            .side_out  (dv_side[j+1])
        );
    end

    always_comb
    begin
        if (dv_side[DIV_CELLS].zero)
        begin
            out_next.steer_x   = '0;
            out_next.steer_z   = '0;
            out_next.at_center = 1'b1;
        end
        else
        begin
            out_next.steer_x   = finish(dv_side[DIV_CELLS].dx, dv_x[DIV_CELLS],
                                        dv_side[DIV_CELLS].neg_x);
            out_next.steer_z   = finish(dv_side[DIV_CELLS].dz, dv_z[DIV_CELLS],
                                        dv_side[DIV_CELLS].neg_z);
            out_next.at_center = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    a_sqrt_rem: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid[SQRT_CELLS] |->
            {2'b00, sq_st[SQRT_CELLS].rem} <= {1'b0, sq_st[SQRT_CELLS].root, 1'b0})
        else $error("square root remainder exceeds twice the root");

    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[DIV_CELLS] && !dv_side[DIV_CELLS].zero |->
            dv_x[DIV_CELLS].rem < dv_side[DIV_CELLS].len &&
            dv_z[DIV_CELLS].rem < dv_side[DIV_CELLS].len)
        else $error("divider remainder not below the length");

    a_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
        p3_valid_reg |-> p3_side_reg.zero == (p3_side_reg.dx == 33'sd0 &&
                                              p3_side_reg.dz == 33'sd0))
        else $error("zero length disagrees with the offset");

    a_center_out: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid[DIV_CELLS] && dv_side[DIV_CELLS].zero |=>
            res_valid && res.at_center && res.steer_x == 32'sd0 && res.steer_z == 32'sd0)
        else $error("request at the center did not give a zero result");

endmodule

// ===== hw/rtl/cvs_sqrt_cell.sv =====
// One cell of the square root chain; it settles one root bit per stage.
// Depends on cvs_pkg for the cell state and the carried request data.
module cvs_sqrt_cell
    import cvs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     valid_in,
    input  sqrt_st_t st_in,
    input  side_a_t  side_in,
    output logic     valid_out,
    output sqrt_st_t st_out,
    output side_a_t  side_out
);

    logic     valid_reg;
    sqrt_st_t st_reg;
    sqrt_st_t st_next;
    side_a_t  side_reg;
    logic [36:0] rem_sh;
    logic [36:0] trial;

    always_comb
    begin
        rem_sh = {st_in.rem, st_in.s[65:64]};
        trial  = {2'b00, st_in.root, 2'b01};
        st_next.s = {st_in.s[63:0], 2'b00};
        if (rem_sh >= trial)
        begin
            st_next.rem  = 35'(rem_sh - trial);
            st_next.root = {st_in.root[31:0], 1'b1};
        end
        else
        begin
            st_next.rem  = rem_sh[34:0];
            st_next.root = {st_in.root[31:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        st_reg   <= st_next;
        side_reg <= side_in;
    end

    assign valid_out = valid_reg;
    assign st_out    = st_reg;
    assign side_out  = side_reg;

endmodule

// ===== hw/rtl/cvs_div_cell.sv =====
// One cell of the divider chain; it settles one quotient bit for both lanes.
// Depends on cvs_pkg for the lane state and the carried request data.
module cvs_div_cell
    import cvs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      valid_in,
    input  div_lane_t x_in,
    input  div_lane_t z_in,
    input  side_b_t   side_in,
    output logic      valid_out,
    output div_lane_t x_out,
    output div_lane_t z_out,
    output side_b_t   side_out
);

    logic      valid_reg;
    div_lane_t x_reg;
    div_lane_t z_reg;
    div_lane_t x_next;
    div_lane_t z_next;
    side_b_t   side_reg;

    function automatic div_lane_t step(input div_lane_t l, input logic [32:0] len);
        logic [33:0] rem_sh;
        logic [33:0] dvs;
        div_lane_t   r;
        rem_sh = {l.rem, l.num[64]};
        dvs    = {1'b0, len};
        r.num  = {l.num[63:0], 1'b0};
        r.ovf  = l.ovf | l.q[40];
        if (rem_sh >= dvs)
        begin
            r.rem = 33'(rem_sh - dvs);
            r.q   = {l.q[39:0], 1'b1};
        end
        else
        begin
            r.rem = rem_sh[32:0];
            r.q   = {l.q[39:0], 1'b0};
        end
        return r;
    endfunction

    always_comb
    begin
        x_next = step(x_in, side_in.len);
        z_next = step(z_in, side_in.len);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        z_reg    <= z_next;
        side_reg <= side_in;
    end

    assign valid_out = valid_reg;
    assign x_out     = x_reg;
    assign z_out     = z_reg;
    assign side_out  = side_reg;

endmodule
